[src/cslep_pkg.sv]
// Shared types and constants for the clock sync start link endpoint.
package cslep_pkg;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_PING_REPLY   = 3'd1,
        OP_STATUS_REPLY = 3'd2,
        OP_START_SIGNAL = 3'd3,
        OP_START_RACE   = 3'd4,
        OP_CLEAR_RACE   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PING   = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_START  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_WAIT_ACK    = 2'd1,
        PH_WAIT_SIGNAL = 2'd2
    } t_phase;

    localparam logic [1:0] CFG_PING_INTERVAL   = 2'd0;
    localparam logic [1:0] CFG_STATUS_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_RETRY_INTERVAL  = 2'd2;
    localparam logic [1:0] CFG_OFFSET_WINDOW   = 2'd3;

    localparam logic [15:0] RST_PING_INTERVAL   = 16'd5050;
    localparam logic [15:0] RST_STATUS_INTERVAL = 16'd3000;
    localparam logic [15:0] RST_RETRY_INTERVAL  = 16'd250;
    localparam logic [15:0] RST_OFFSET_WINDOW   = 16'd100;

    typedef struct packed {
        logic [2:0]         operation;
        logic [31:0]        now_ms;
        logic               msg_request;
        logic               msg_acknowledge;
        logic [31:0]        msg_timestamp;
        logic [31:0]        msg_device_clock;
        logic signed [7:0]  msg_rssi;
        logic [7:0]         msg_battery_device;
        logic [7:0]         msg_battery_relay;
    } t_in;

    typedef struct packed {
        logic [1:0]         send_kind;
        logic               send_request;
        logic               send_acknowledge;
        logic [31:0]        send_timestamp;
        logic               last;
        logic signed [31:0] latency;
        logic signed [31:0] clock_offset;
        logic [31:0]        race_start;
        logic signed [7:0]  link_rssi;
        logic [7:0]         device_charge;
        logic [7:0]         relay_charge;
        logic [1:0]         request_phase;
    } t_out;

    typedef struct packed {
        logic [31:0] latency;
        logic [31:0] clock_offset;
        logic [31:0] race_start;
        logic [7:0]  link_rssi;
        logic [7:0]  device_charge;
        logic [7:0]  relay_charge;
        t_phase      request_phase;
    } t_status;

    // Work left by one item: which messages go out and what they carry.
    typedef struct packed {
        logic        send_ping;
        logic        send_status;
        logic        send_retry;
        logic        send_echo;
        logic [31:0] tick_time;
        logic [31:0] echo_time;
        t_status     status;
    } t_bundle;

endpackage

[src/cslep_in_reg.sv]
// Input register stage for received items.
module cslep_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cslep_pkg::t_in  i_item,
    input  logic            i_take,
    output logic            o_valid,
    output cslep_pkg::t_in  o_item
);
    import cslep_pkg::*;

    logic r_valid;
    t_in  r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[src/cslep_core.sv]
// Link state, configuration registers and per-item update logic.
module cslep_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_commit,
    input  cslep_pkg::t_in      i_item,
    output cslep_pkg::t_bundle  o_bundle
);
    import cslep_pkg::*;

    logic [15:0] r_ping_int, r_status_int, r_retry_int, r_window;
    logic [31:0] r_internal, r_last_ping, r_last_status, r_last_retry;
    t_phase      r_phase;
    logic [31:0] r_latency, r_offset, r_race_start;
    logic [7:0]  r_rssi, r_dev_charge, r_rel_charge;

    logic [31:0] n_internal, n_last_ping, n_last_status, n_last_retry;
    t_phase      n_phase;
    logic [31:0] n_latency, n_offset, n_race_start;
    logic [7:0]  n_rssi, n_dev_charge, n_rel_charge;

    logic [31:0] lat, half, off_new;
    logic signed [32:0] diff, sum, sum_adj, win, neg_win;
    logic        in_win;
    logic        sp, ss, sr, echo;

    always_comb begin
        lat     = r_internal - i_item.msg_timestamp;
        half    = 32'($signed(lat + {31'd0, lat[31]}) >>> 1);
        off_new = i_item.msg_timestamp - i_item.msg_device_clock + half;
        diff    = $signed({r_offset[31], r_offset}) - $signed({off_new[31], off_new});
        sum     = $signed({r_offset[31], r_offset}) + $signed({off_new[31], off_new});
        sum_adj = (sum + $signed({32'd0, sum[32]})) >>> 1;
        win     = $signed({17'd0, r_window});
        neg_win = -win;
        in_win  = (diff < win) && (diff > neg_win);
    end

    always_comb begin
        n_internal    = r_internal;
        n_last_ping   = r_last_ping;
        n_last_status = r_last_status;
        n_last_retry  = r_last_retry;
        n_phase       = r_phase;
        n_latency     = r_latency;
        n_offset      = r_offset;
        n_race_start  = r_race_start;
        n_rssi        = r_rssi;
        n_dev_charge  = r_dev_charge;
        n_rel_charge  = r_rel_charge;
        sp            = 1'b0;
        ss            = 1'b0;
        sr            = 1'b0;
        echo          = 1'b0;
        case (i_item.operation)
            OP_TICK: begin
                n_internal = i_item.now_ms;
                if ((i_item.now_ms - r_last_ping) > {16'd0, r_ping_int}) begin
                    sp          = 1'b1;
                    n_last_ping = i_item.now_ms;
                end
                if ((i_item.now_ms - r_last_status) > {16'd0, r_status_int}) begin
                    ss            = 1'b1;
                    n_last_status = i_item.now_ms;
                end
                if (r_phase == PH_WAIT_ACK
                        && (i_item.now_ms - r_last_retry) > {16'd0, r_retry_int}) begin
                    sr           = 1'b1;
                    n_last_retry = i_item.now_ms;
                end
            end
            OP_PING_REPLY: begin
                if (!i_item.msg_request) begin
                    n_latency = lat;
                end
            end
            OP_STATUS_REPLY: begin
                if (!i_item.msg_request) begin
                    n_rssi       = i_item.msg_rssi;
                    n_dev_charge = i_item.msg_battery_device;
                    n_rel_charge = i_item.msg_battery_relay;
                    n_latency    = lat;
                    if (r_offset == 32'd0) begin
                        n_offset = off_new;
                    end else if (in_win) begin
                        n_offset = sum_adj[31:0];
                    end
                end
            end
            OP_START_SIGNAL: begin
                if (i_item.msg_request && i_item.msg_acknowledge) begin
                    n_phase = PH_WAIT_SIGNAL;
                end else if (!i_item.msg_request && !i_item.msg_acknowledge
                        && i_item.msg_timestamp != 32'd0) begin
                    n_race_start = i_item.msg_timestamp + r_offset;
                    n_phase      = PH_IDLE;
                    echo         = 1'b1;
                end
            end
            OP_START_RACE: begin
                n_last_retry = 32'd0;
                n_phase      = PH_WAIT_ACK;
            end
            OP_CLEAR_RACE: begin
                n_race_start = 32'd0;
            end
            default: begin
            end
        endcase

        o_bundle.send_ping            = sp;
        o_bundle.send_status          = ss;
        o_bundle.send_retry           = sr;
        o_bundle.send_echo            = echo;
        o_bundle.tick_time            = n_internal;
        o_bundle.echo_time            = i_item.msg_timestamp;
        o_bundle.status.latency       = n_latency;
        o_bundle.status.clock_offset  = n_offset;
        o_bundle.status.race_start    = n_race_start;
        o_bundle.status.link_rssi     = n_rssi;
        o_bundle.status.device_charge = n_dev_charge;
        o_bundle.status.relay_charge  = n_rel_charge;
        o_bundle.status.request_phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_int   <= RST_PING_INTERVAL;
            r_status_int <= RST_STATUS_INTERVAL;
            r_retry_int  <= RST_RETRY_INTERVAL;
            r_window     <= RST_OFFSET_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PING_INTERVAL:   r_ping_int   <= i_cfg_data;
                CFG_STATUS_INTERVAL: r_status_int <= i_cfg_data;
                CFG_RETRY_INTERVAL:  r_retry_int  <= i_cfg_data;
                CFG_OFFSET_WINDOW:   r_window     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_internal    <= '0;
            r_last_ping   <= '0;
            r_last_status <= '0;
            r_last_retry  <= '0;
            r_phase       <= PH_IDLE;
            r_latency     <= '0;
            r_offset      <= '0;
            r_race_start  <= '0;
            r_rssi        <= '0;
            r_dev_charge  <= '0;
            r_rel_charge  <= '0;
        end else if (i_commit) begin
            r_internal    <= n_internal;
            r_last_ping   <= n_last_ping;
            r_last_status <= n_last_status;
            r_last_retry  <= n_last_retry;
            r_phase       <= n_phase;
            r_latency     <= n_latency;
            r_offset      <= n_offset;
            r_race_start  <= n_race_start;
            r_rssi        <= n_rssi;
            r_dev_charge  <= n_dev_charge;
            r_rel_charge  <= n_rel_charge;
        end
    end

    a_start_race: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && i_item.operation == OP_START_RACE |=> r_phase == PH_WAIT_ACK)
        else $error("start race did not enter wait-ack phase");

    a_retry_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && sr |=> r_last_retry == $past(i_item.now_ms))
        else $error("retry time not recorded");

endmodule

[src/cslep_emit.sv]
// Result register: sends one item's messages, one transfer per ready cycle.
module cslep_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cslep_pkg::t_bundle  i_bundle,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output cslep_pkg::t_out     o_out
);
    import cslep_pkg::*;

    logic       r_valid;
    logic [3:0] r_pend;
    t_bundle    r_b;

    logic [3:0] sel, rest;
    logic       is_last;

    always_comb begin
        sel = 4'b0000;
        if (r_pend[3]) begin
            sel = 4'b1000;
        end else if (r_pend[2]) begin
            sel = 4'b0100;
        end else if (r_pend[1]) begin
            sel = 4'b0010;
        end else if (r_pend[0]) begin
            sel = 4'b0001;
        end
        rest    = r_pend & ~sel;
        is_last = (rest == 4'b0000);
        o_free  = !r_valid || (i_ready && is_last);

        o_out.send_kind        = KIND_NONE;
        o_out.send_request     = 1'b0;
        o_out.send_acknowledge = 1'b0;
        o_out.send_timestamp   = 32'd0;
        case (sel)
            4'b1000: begin
                o_out.send_kind      = KIND_PING;
                o_out.send_request   = 1'b1;
                o_out.send_timestamp = r_b.tick_time;
            end
            4'b0100: begin
                o_out.send_kind      = KIND_STATUS;
                o_out.send_request   = 1'b1;
                o_out.send_timestamp = r_b.tick_time;
            end
            4'b0010: begin
                o_out.send_kind    = KIND_START;
                o_out.send_request = 1'b1;
            end
            4'b0001: begin
                o_out.send_kind        = KIND_START;
                o_out.send_acknowledge = 1'b1;
                o_out.send_timestamp   = r_b.echo_time;
            end
            default: begin
            end
        endcase
        o_out.last          = is_last;
        o_out.latency       = r_b.status.latency;
        o_out.clock_offset  = r_b.status.clock_offset;
        o_out.race_start    = r_b.status.race_start;
        o_out.link_rssi     = r_b.status.link_rssi;
        o_out.device_charge = r_b.status.device_charge;
        o_out.relay_charge  = r_b.status.relay_charge;
        o_out.request_phase = r_b.status.request_phase;
    end

    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 4'b0000;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_pend  <= {i_bundle.send_ping, i_bundle.send_status,
                        i_bundle.send_retry, i_bundle.send_echo};
        end else if (r_valid && i_ready) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= i_bundle;
        end
    end

    a_pend_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_load |=> (r_pend & ~$past(r_pend)) == 4'b0000)
        else $error("pending message appeared without a load");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && is_last && !i_load |=> !r_valid)
        else $error("result register still valid after final transfer");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("bundle loaded while results pending");

endmodule

[src/clock_sync_start_link_endpoint_unit.sv]
// Top level of the clock sync start link endpoint.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_ready | o_out (t_out)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// An item is held in the input register, then its state update and
// results are computed in one pass and loaded into the result register.
// A tick gives one to three results, other items one. While i_out_ready is high,
// results go one transfer per cycle, and one-result items sustain that rate.
// Active-low synchronous reset clears valid bits and link state; intervals get defaults.
// A stalled output holds the result register, then the input register, then o_in_ready.
module clock_sync_start_link_endpoint_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cslep_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cslep_pkg::t_out o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import cslep_pkg::*;

    logic    item_valid, emit_free, take;
    t_in     item;
    t_bundle bundle;

    assign take = item_valid && emit_free;

    cslep_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    cslep_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_commit   (take),
        .i_item     (item),
        .o_bundle   (bundle)
    );

    cslep_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_bundle (bundle),
        .o_free   (emit_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_out    (o_out)
    );

endmodule
